[hdl/ivci_pkg.sv]
// ----------------------------------------------------------------------------
// ivci_pkg: shared constants and tables for the i-v curve interpolator
// holds the 73-point i-v table in millionths and the helpers that turn it
// into fixed-point tables at elaboration
// ----------------------------------------------------------------------------
package ivci_pkg;

    localparam int VoltageWidth   = 18;
    localparam int CurrentWidth   = 27;
    localparam int TablePoints    = 73;
    localparam int FractionBits   = 10;
    localparam int RomDepth       = 256;
    localparam int RomIdxWidth    = 8;
    localparam int RomListed      = 73;
    localparam int RomIntBits     = 7;
    localparam int InterLimitBits = 38;
    localparam int SumLimitBits   = 40;
    localparam int GroupSize      = 16;
    localparam int GroupBits      = 4;
    localparam int MulSplit       = 20;

    localparam longint Micro = 1000000;

    localparam int RomVoltMicro [RomListed] = '{
        -4386792, -3891509, -3396226, -2971698, -2617925, -2122642, -1485849, -849057,
        -283019, 212264, 636792, 990566, 1273585, 1556604, 1698113, 1910377,
        1981132, 2122642, 2405660, 2688679, 2971698, 3254717, 3820755, 4316038,
        4811321, 5377358, 6014151, 7216981, 8419811, 9905660, 11320755, 12806604,
        14575472, 16202830, 17759434, 20235849, 22500000, 24551887, 27099057, 29009434,
        30778302, 32476415, 34245283, 36084906, 38066038, 40047170, 42240566, 44433962,
        47051887, 48820755, 50731132, 52500000, 54764151, 56745283, 58797170, 60849057,
        63042453, 64952830, 66792453, 68773585, 70613208, 71816038, 72877358, 73938679,
        75141509, 75990566, 76768868, 77617925, 78466981, 79316038, 79811321, 80306604,
        80518868
    };

    localparam int RomCurrMicro [RomListed] = '{
        217617, 362694, 507772, 580311, 797927, 943005, 1088083, 1450777,
        1740933, 2103627, 2538860, 2974093, 3554404, 4207254, 4787565, 5367876,
        6020725, 6673575, 28000000, 28435233, 28797927, 29233161, 29523316, 29740933,
        29958549, 30103627, 30176166, 30248705, 30393782, 30466321, 30611399, 30683938,
        30829016, 30901554, 31046632, 31191710, 31336788, 31626943, 31844560, 31917098,
        32134715, 32279793, 32352332, 32497409, 32642487, 32787565, 33005181, 33150259,
        33222798, 33440415, 33658031, 33803109, 34020725, 34383420, 34746114, 35036269,
        35326425, 35616580, 36124352, 36704663, 37357513, 37937824, 38518135, 39243523,
        40113990, 40839378, 41709845, 42580311, 43668394, 44756477, 45481865, 46207254,
        46715026
    };

    typedef longint rom_table_t [RomDepth];

    // millionths to fixed point, nearest with ties away from zero
    function automatic longint rom_to_q(input longint micro, input int f);
        longint m;
        longint q;
        m = micro <<< f;
        if (m < 0) begin
            q = -((Micro / 2 - m) / Micro);
        end else begin
            q = (m + Micro / 2) / Micro;
        end
        return q;
    endfunction

    function automatic rom_table_t build_volt_q(input int f);
        rom_table_t tab;
        for (int i = 0; i < RomDepth; i++) begin
            if (i < RomListed) begin
                tab[i] = rom_to_q(longint'(RomVoltMicro[i]), f);
            end else begin
                tab[i] = 0;
            end
        end
        return tab;
    endfunction

    function automatic rom_table_t build_curr_q(input int f);
        rom_table_t tab;
        for (int i = 0; i < RomDepth; i++) begin
            if (i < RomListed) begin
                tab[i] = rom_to_q(longint'(RomCurrMicro[i]), f);
            end else begin
                tab[i] = 0;
            end
        end
        return tab;
    endfunction

endpackage

[hdl/iv_curve_interpolator.sv]
// ----------------------------------------------------------------------------
// iv_curve_interpolator: piecewise linear i-v curve lookup
// maps a signed voltage to a current density over a fixed i-v table, with
// linear extension below the table, a quadratic tail above it, optional
// scaling by ten and output saturation
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  input   | s_valid / s_ready  | s_voltage (18 b signed), s_scale_to_si (1 b)
//  result  | m_valid / m_ready  | m_current (27 b signed)
//
//  one beat per cycle while no result beat is held at the output; a
//  restoring divider resolves one quotient bit per stage for the segment
//  interpolation
//  aresetn clears only the stage valid bits
//  a result beat held at the output stalls every stage together
// ----------------------------------------------------------------------------
module iv_curve_interpolator #(
    parameter int TABLE_POINTS  = ivci_pkg::TablePoints,
    parameter int FRACTION_BITS = ivci_pkg::FractionBits
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [ivci_pkg::VoltageWidth-1:0] s_voltage,
    input  logic                                    s_scale_to_si,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [ivci_pkg::CurrentWidth-1:0] m_current
);

    localparam int LAST   = TABLE_POINTS - 1;
    localparam int IDX_W  = $clog2(TABLE_POINTS);
    localparam int NC     = TABLE_POINTS - 2;
    localparam int NG     = (NC + ivci_pkg::GroupSize - 1) / ivci_pkg::GroupSize;
    localparam int NCP    = NG * ivci_pkg::GroupSize;
    localparam int GS     = ivci_pkg::GroupSize;
    localparam int GB     = ivci_pkg::GroupBits;
    localparam int SPL    = ivci_pkg::MulSplit;
    localparam int RI_W   = ivci_pkg::RomIdxWidth;
    localparam int VW     = ivci_pkg::VoltageWidth;
    localparam int OW     = ivci_pkg::CurrentWidth;
    localparam int RW     = ivci_pkg::RomIntBits + FRACTION_BITS + 1;
    localparam int DI_W   = RW + 1;
    localparam int DT_W   = ((VW > RW) ? VW : RW) + 1;
    localparam int NUM_W  = DI_W + DT_W;
    localparam int DEN_W  = DI_W;
    localparam int CV_W   = ivci_pkg::InterLimitBits + 1;
    localparam int CD_W   = CV_W + DT_W;
    localparam int PL_W   = SPL + DT_W;
    localparam int PH_W   = CV_W - SPL + DT_W;
    localparam int QD_W   = CD_W - FRACTION_BITS;
    localparam int MAXW   = (NUM_W > QD_W) ? NUM_W : QD_W;
    localparam int SUM_W  = MAXW + 3;
    localparam int LIM_W  = ivci_pkg::SumLimitBits + 2;
    localparam int XW     = LIM_W + 4;
    localparam int N_ST   = NUM_W + 11;

    localparam ivci_pkg::rom_table_t VOLT_Q = ivci_pkg::build_volt_q(FRACTION_BITS);
    localparam ivci_pkg::rom_table_t CURR_Q = ivci_pkg::build_curr_q(FRACTION_BITS);

    // curvature of the last two segments, fixed at elaboration
    localparam longint ONE    = longint'(1) <<< FRACTION_BITS;
    localparam longint ILIM   = longint'(1) <<< ivci_pkg::InterLimitBits;
    localparam longint DX0    = VOLT_Q[LAST - 1] - VOLT_Q[LAST - 2];
    localparam longint DX1    = VOLT_Q[LAST] - VOLT_Q[LAST - 1];
    localparam longint A_D0   = (DX0 < 0) ? -DX0 : DX0;
    localparam longint A_D1   = (DX1 < 0) ? -DX1 : DX1;
    localparam longint S_D0   = (A_D0 == 0) ? 1 : A_D0;
    localparam longint S_D1   = (A_D1 == 0) ? 1 : A_D1;
    localparam longint N0     = (CURR_Q[LAST - 1] - CURR_Q[LAST - 2]) * ONE;
    localparam longint N1     = (CURR_Q[LAST] - CURR_Q[LAST - 1]) * ONE;
    localparam longint A_N0   = (N0 < 0) ? -N0 : N0;
    localparam longint A_N1   = (N1 < 0) ? -N1 : N1;
    localparam longint M_S0   = (A_N0 + A_D0 / 2) / S_D0;
    localparam longint M_S1   = (A_N1 + A_D1 / 2) / S_D1;
    localparam longint S0     = ((N0 < 0) != (DX0 < 0)) ? -M_S0 : M_S0;
    localparam longint S1     = ((N1 < 0) != (DX1 < 0)) ? -M_S1 : M_S1;
    localparam longint NK     = (S1 - S0) * ONE;
    localparam longint A_NK   = (NK < 0) ? -NK : NK;
    localparam longint M_K    = (A_NK + A_D0 / 2) / S_D0;
    localparam longint K_RAW  = ((NK < 0) != (DX0 < 0)) ? -M_K : M_K;
    localparam longint K_CLP  = (K_RAW > ILIM) ? ILIM : ((K_RAW < -ILIM) ? -ILIM : K_RAW);
    localparam longint CURV   = (DX0 == 0 || DX1 == 0) ? 0 : K_CLP;
    localparam logic            CURV_NEG = (CURV < 0);
    localparam logic [CV_W-1:0] CURV_MAG = CV_W'((CURV < 0) ? -CURV : CURV);

    localparam logic [CD_W-1:0] T_RND   = CD_W'(longint'(1) <<< (FRACTION_BITS - 1));
    localparam logic [CD_W-1:0] Q_RND   = CD_W'(ONE);
    localparam logic [CD_W-1:0] T_LIM   = CD_W'(ILIM);
    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(longint'(1) <<< ivci_pkg::SumLimitBits);
    localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_HI;
    localparam logic signed [XW-1:0] OUT_HI = XW'((longint'(1) <<< (OW - 1)) - 1);
    localparam logic signed [XW-1:0] OUT_LO = XW'(-(longint'(1) <<< (OW - 1)));

    typedef struct packed {
        logic signed [VW-1:0] v;
        logic                 si;
        logic                 above;
        logic [NCP-1:0]       gt;
    } p1_t;

    typedef struct packed {
        logic signed [VW-1:0]      v;
        logic                      si;
        logic                      above;
        logic [NG-1:0]             hit;
        logic [NG-1:0][GB-1:0]     pos;
    } p2_t;

    typedef struct packed {
        logic signed [VW-1:0] v;
        logic                 si;
        logic                 above;
        logic [IDX_W-1:0]     idx;
    } p3_t;

    typedef struct packed {
        logic signed [VW-1:0] v;
        logic                 si;
        logic                 above;
        logic signed [RW-1:0] vlo;
        logic signed [RW-1:0] vhi;
        logic signed [RW-1:0] clo;
        logic signed [RW-1:0] chi;
    } p4_t;

    typedef struct packed {
        logic                   si;
        logic                   above;
        logic signed [RW-1:0]   clo;
        logic signed [RW-1:0]   chi;
        logic signed [DI_W-1:0] seg;
        logic signed [DI_W-1:0] di;
        logic signed [DT_W-1:0] dt;
    } p5_t;

    typedef struct packed {
        logic                    si;
        logic                    above;
        logic signed [RW-1:0]    clo;
        logic signed [RW-1:0]    chi;
        logic                    seg_zero;
        logic                    seg_neg;
        logic [DEN_W-1:0]        den;
        logic signed [NUM_W-1:0] num;
        logic                    dt_neg;
        logic [DT_W-1:0]         dt_mag;
        logic [PL_W-1:0]         pp_lo;
        logic [PH_W-1:0]         pp_hi;
    } p6_t;

    typedef struct packed {
        logic                 si;
        logic signed [RW-1:0] clo;
        logic signed [RW-1:0] chi;
        logic                 seg_zero;
        logic                 lin_neg;
        logic [DEN_W-1:0]     den;
        logic [NUM_W-1:0]     num_mag;
        logic                 t_neg;
        logic [CV_W-1:0]      t_mag;
        logic                 dt_neg;
        logic [DT_W-1:0]      dt_mag;
    } p7_t;

    typedef struct packed {
        logic                 si;
        logic signed [RW-1:0] clo;
        logic signed [RW-1:0] chi;
        logic                 seg_zero;
        logic                 lin_neg;
        logic [DEN_W-1:0]     den;
        logic [NUM_W-1:0]     num_mag;
        logic                 quad_neg;
        logic [PL_W-1:0]      qp_lo;
        logic [PH_W-1:0]      qp_hi;
    } p8_t;

    typedef struct packed {
        logic                 si;
        logic signed [RW-1:0] clo;
        logic signed [RW-1:0] chi;
        logic                 seg_zero;
        logic                 lin_neg;
        logic                 quad_neg;
        logic [QD_W-1:0]      quad_mag;
        logic [DEN_W-1:0]     den;
        logic [DEN_W-1:0]     rem;
        logic [NUM_W-1:0]     num;
        logic [NUM_W-1:0]     quo;
    } dv_t;

    typedef struct packed {
        logic                    si;
        logic signed [LIM_W-1:0] r;
    } sum_t;

    logic              adv;
    logic [N_ST-1:0]   vld_reg;
    logic [NCP-1:0]    gt_cmp;
    logic [RI_W-1:0]   ri_hi;
    logic [RI_W-1:0]   ri_lo;

    p1_t  p1_reg, p1_next;
    p2_t  p2_reg, p2_next;
    p3_t  p3_reg, p3_next;
    p4_t  p4_reg, p4_next;
    p5_t  p5_reg, p5_next;
    p6_t  p6_reg, p6_next;
    p7_t  p7_reg, p7_next;
    p8_t  p8_reg, p8_next;
    dv_t  dv_reg  [NUM_W+1];
    dv_t  dv_next [NUM_W+1];
    sum_t sum_reg, sum_next;
    logic signed [OW-1:0] m_current_reg, m_current_next;

    assign adv       = !vld_reg[N_ST-1] || m_ready;
    assign s_ready   = adv;
    assign m_valid   = vld_reg[N_ST-1];
    assign m_current = m_current_reg;

    // compare against every inner table point, padding reads as above
    for (genvar k = 0; k < NCP; k++) begin : g_cmp
        if (k < NC) begin : g_pt
            assign gt_cmp[k] = longint'(s_voltage) > VOLT_Q[k + 1];
        end else begin : g_pad
            assign gt_cmp[k] = 1'b1;
        end
    end

    always_comb begin
        p1_next.v     = s_voltage;
        p1_next.si    = s_scale_to_si;
        p1_next.above = longint'(s_voltage) > VOLT_Q[LAST];
        p1_next.gt    = gt_cmp;
    end

    // first point not below the input, per group of points
    always_comb begin
        p2_next.v     = p1_reg.v;
        p2_next.si    = p1_reg.si;
        p2_next.above = p1_reg.above;
        for (int g = 0; g < NG; g++) begin
            p2_next.hit[g] = ~&p1_reg.gt[g*GS +: GS];
            p2_next.pos[g] = '0;
            for (int j = GS - 1; j >= 0; j--) begin
                if (!p1_reg.gt[g*GS + j]) begin
                    p2_next.pos[g] = GB'(j);
                end
            end
        end
    end

    always_comb begin
        p3_next.v     = p2_reg.v;
        p3_next.si    = p2_reg.si;
        p3_next.above = p2_reg.above;
        p3_next.idx   = IDX_W'(LAST);
        for (int g = NG - 1; g >= 0; g--) begin
            if (p2_reg.hit[g]) begin
                p3_next.idx = IDX_W'(g * GS + int'(p2_reg.pos[g]) + 1);
            end
        end
    end

    assign ri_hi = RI_W'(p3_reg.idx);
    assign ri_lo = RI_W'(p3_reg.idx - 1'b1);

    always_comb begin
        p4_next.v     = p3_reg.v;
        p4_next.si    = p3_reg.si;
        p4_next.above = p3_reg.above;
        p4_next.vhi   = VOLT_Q[ri_hi][RW-1:0];
        p4_next.vlo   = VOLT_Q[ri_lo][RW-1:0];
        p4_next.chi   = CURR_Q[ri_hi][RW-1:0];
        p4_next.clo   = CURR_Q[ri_lo][RW-1:0];
    end

    always_comb begin
        p5_next.si    = p4_reg.si;
        p5_next.above = p4_reg.above;
        p5_next.clo   = p4_reg.clo;
        p5_next.chi   = p4_reg.chi;
        p5_next.seg   = DI_W'(p4_reg.vhi) - DI_W'(p4_reg.vlo);
        p5_next.di    = DI_W'(p4_reg.chi) - DI_W'(p4_reg.clo);
        p5_next.dt    = DT_W'(p4_reg.v) - DT_W'(p4_reg.vlo);
    end

    always_comb begin
        p6_next.si       = p5_reg.si;
        p6_next.above    = p5_reg.above;
        p6_next.clo      = p5_reg.clo;
        p6_next.chi      = p5_reg.chi;
        p6_next.seg_zero = (p5_reg.seg == '0);
        p6_next.seg_neg  = (p5_reg.seg < 0);
        p6_next.den      = (p5_reg.seg < 0) ? DEN_W'(-p5_reg.seg) : DEN_W'(p5_reg.seg);
        p6_next.num      = NUM_W'(p5_reg.di) * NUM_W'(p5_reg.dt);
        p6_next.dt_neg   = (p5_reg.dt < 0);
        p6_next.dt_mag   = (p5_reg.dt < 0) ? DT_W'(-p5_reg.dt) : DT_W'(p5_reg.dt);
        p6_next.pp_lo    = PL_W'(CURV_MAG[SPL-1:0]) * PL_W'(p6_next.dt_mag);
        p6_next.pp_hi    = PH_W'(CURV_MAG[CV_W-1:SPL]) * PH_W'(p6_next.dt_mag);
    end

    // rounding offsets for the divider, first rounded shift of the tail
    always_comb begin
        logic [CD_W-1:0] cd;
        logic [CD_W-1:0] rnd;
        cd  = (CD_W'(p6_reg.pp_hi) << SPL) + CD_W'(p6_reg.pp_lo);
        rnd = (cd + T_RND) >> FRACTION_BITS;
        p7_next.si       = p6_reg.si;
        p7_next.clo      = p6_reg.clo;
        p7_next.chi      = p6_reg.chi;
        p7_next.seg_zero = p6_reg.seg_zero;
        p7_next.lin_neg  = (p6_reg.num < 0) ^ p6_reg.seg_neg;
        p7_next.den      = p6_reg.den;
        p7_next.num_mag  = NUM_W'((p6_reg.num < 0) ? -p6_reg.num : p6_reg.num)
                           + NUM_W'(p6_reg.den >> 1);
        p7_next.t_neg    = CURV_NEG ^ p6_reg.dt_neg;
        if (!p6_reg.above) begin
            p7_next.t_mag = '0;
        end else if (rnd > T_LIM) begin
            p7_next.t_mag = CV_W'(T_LIM);
        end else begin
            p7_next.t_mag = CV_W'(rnd);
        end
        p7_next.dt_neg   = p6_reg.dt_neg;
        p7_next.dt_mag   = p6_reg.dt_mag;
    end

    always_comb begin
        p8_next.si       = p7_reg.si;
        p8_next.clo      = p7_reg.clo;
        p8_next.chi      = p7_reg.chi;
        p8_next.seg_zero = p7_reg.seg_zero;
        p8_next.lin_neg  = p7_reg.lin_neg;
        p8_next.den      = p7_reg.den;
        p8_next.num_mag  = p7_reg.num_mag;
        p8_next.quad_neg = p7_reg.t_neg ^ p7_reg.dt_neg;
        p8_next.qp_lo    = PL_W'(p7_reg.t_mag[SPL-1:0]) * PL_W'(p7_reg.dt_mag);
        p8_next.qp_hi    = PH_W'(p7_reg.t_mag[CV_W-1:SPL]) * PH_W'(p7_reg.dt_mag);
    end

    always_comb begin
        logic [CD_W-1:0] tdt;
        tdt = (CD_W'(p8_reg.qp_hi) << SPL) + CD_W'(p8_reg.qp_lo);
        dv_next[0].si       = p8_reg.si;
        dv_next[0].clo      = p8_reg.clo;
        dv_next[0].chi      = p8_reg.chi;
        dv_next[0].seg_zero = p8_reg.seg_zero;
        dv_next[0].lin_neg  = p8_reg.lin_neg;
        dv_next[0].quad_neg = p8_reg.quad_neg;
        dv_next[0].quad_mag = QD_W'((tdt + Q_RND) >> (FRACTION_BITS + 1));
        dv_next[0].den      = p8_reg.den;
        dv_next[0].rem      = '0;
        dv_next[0].num      = p8_reg.num_mag;
        dv_next[0].quo      = '0;
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < NUM_W; k++) begin : g_div
        always_comb begin
            logic [DEN_W:0] trial;
            trial = {dv_reg[k].rem, dv_reg[k].num[NUM_W-1]};
            dv_next[k+1]     = dv_reg[k];
            dv_next[k+1].num = dv_reg[k].num << 1;
            if (trial >= {1'b0, dv_reg[k].den}) begin
                dv_next[k+1].rem = DEN_W'(trial - {1'b0, dv_reg[k].den});
                dv_next[k+1].quo = {dv_reg[k].quo[NUM_W-2:0], 1'b1};
            end else begin
                dv_next[k+1].rem = trial[DEN_W-1:0];
                dv_next[k+1].quo = {dv_reg[k].quo[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] lin;
        logic signed [SUM_W-1:0] quad;
        logic signed [SUM_W-1:0] r;
        lin  = $signed(SUM_W'(dv_reg[NUM_W].quo));
        quad = $signed(SUM_W'(dv_reg[NUM_W].quad_mag));
        if (dv_reg[NUM_W].lin_neg) begin
            lin = -lin;
        end
        if (dv_reg[NUM_W].quad_neg) begin
            quad = -quad;
        end
        if (dv_reg[NUM_W].seg_zero) begin
            r = SUM_W'(dv_reg[NUM_W].chi);
        end else begin
            r = SUM_W'(dv_reg[NUM_W].clo) + lin + quad;
        end
        if (r > SUM_HI) begin
            r = SUM_HI;
        end else if (r < SUM_LO) begin
            r = SUM_LO;
        end
        sum_next.si = dv_reg[NUM_W].si;
        sum_next.r  = LIM_W'(r);
    end

    // times ten as shift and add, then saturate to the port
    always_comb begin
        logic signed [XW-1:0] rx;
        logic signed [XW-1:0] x;
        rx = XW'(sum_reg.r);
        x  = sum_reg.si ? (rx <<< 3) + (rx <<< 1) : rx;
        if (x > OUT_HI) begin
            m_current_next = OW'(OUT_HI);
        end else if (x < OUT_LO) begin
            m_current_next = OW'(OUT_LO);
        end else begin
            m_current_next = OW'(x);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            p3_reg        <= p3_next;
            p4_reg        <= p4_next;
            p5_reg        <= p5_next;
            p6_reg        <= p6_next;
            p7_reg        <= p7_next;
            p8_reg        <= p8_next;
            dv_reg        <= dv_next;
            sum_reg       <= sum_next;
            m_current_reg <= m_current_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[N_ST-2:0], s_valid};
        end
    end

endmodule
